/* rtl/ppm_pkg.sv */
// ----------------------------------------------------------------------------
// ppm_pkg
// Shared widths, sizes and state codes of the phrase proximity matcher.
// ----------------------------------------------------------------------------
package ppm_pkg;

  // Field widths of the item and result ports
  localparam int unsigned TERM_SLOT_W = 3;
  localparam int unsigned TERM_ID_W   = 31;
  localparam int unsigned TERM_LEN_W  = 10;
  localparam int unsigned POS_W       = 24;
  localparam int unsigned REC_W       = 31;
  localparam int unsigned WINDOW_W    = 16;

  // Store sizes
  localparam int unsigned MAX_TERMS     = 8;
  localparam int unsigned MAX_POSITIONS = 64;
  localparam int unsigned SLOT_W        = $clog2(MAX_TERMS);
  localparam int unsigned IDX_W         = $clog2(MAX_POSITIONS);
  localparam int unsigned ADDR_W        = SLOT_W + IDX_W;
  localparam int unsigned LEN_W         = $clog2(MAX_POSITIONS + 1);
  localparam int unsigned COUNT_W       = $clog2(MAX_TERMS + 1);
  localparam int unsigned DEPTH         = MAX_TERMS * MAX_POSITIONS;

  // Fine gap bound and window reset value
  localparam int unsigned FINE_LIMIT   = 4;
  localparam int unsigned WINDOW_RESET = 16;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_ANCHOR,
    ST_SLOT,
    ST_SCAN,
    ST_DONE
  } ppm_state_t;

endpackage

/* rtl/phrase_proximity_matcher_top.sv */
// Load: one item per cycle while not stalled; each valid position for a slot in range
//   with room is written to the list store as it arrives. Search, after the last item:
//   a start step, then per anchor an anchor step plus, for every later slot, a slot
//   step and a scan step per list entry read from the store. When the search ends, the
//   result is loaded into the output register once free; the input stalls until then.
// Reset clears list lengths, term count, control and output valid; window = 16.
// ----------------------------------------------------------------------------
// phrase_proximity_matcher_top
// Loads per-term position lists into a store and searches for the first
// anchor whose terms follow within the window and pass the fine gap test.
// The position store is not cleared; only entries below each fill count are used.
// ----------------------------------------------------------------------------
module phrase_proximity_matcher_top (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_wr_en,
  input  logic [ppm_pkg::WINDOW_W-1:0] cfg_wr_data,
  // item input
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ppm_pkg::TERM_SLOT_W-1:0] term_slot,
  input  logic [ppm_pkg::TERM_ID_W-1:0]   term_id,
  input  logic [ppm_pkg::TERM_LEN_W-1:0]  term_length,
  input  logic [ppm_pkg::POS_W-1:0]       position,
  input  logic                         position_valid,
  input  logic [ppm_pkg::REC_W-1:0]    record_id,
  input  logic                         last_item,
  // result output
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic                         match_found,
  output logic [ppm_pkg::POS_W-1:0]    match_start,
  output logic [ppm_pkg::REC_W-1:0]    record_id_res
);
  import ppm_pkg::*;

  // Position store
  logic [POS_W-1:0]      pos_mem [DEPTH];
  logic [POS_W-1:0]      rd_data;
  logic [ADDR_W-1:0]     rd_addr;
  logic [ADDR_W-1:0]     wr_addr;
  logic                  wr_en;

  // Per-slot tables
  logic [LEN_W-1:0]      list_len [MAX_TERMS];
  logic [TERM_ID_W-1:0]  slot_id  [MAX_TERMS];
  logic [TERM_LEN_W-1:0] slot_tlen [MAX_TERMS];

  // Control and search registers
  ppm_state_t            state, state_next;
  logic [COUNT_W-1:0]    term_count, term_count_next;
  logic [WINDOW_W-1:0]   window;
  logic [REC_W-1:0]      rec_q;
  logic [LEN_W-1:0]      anchor_k, anchor_k_next;
  logic [LEN_W-1:0]      scan_k, scan_k_next;
  logic [COUNT_W-1:0]    cur_slot, cur_slot_next;
  logic [POS_W-1:0]      anchor_pos, anchor_pos_next;
  logic [POS_W-1:0]      prev_pos, prev_pos_next;
  logic [TERM_ID_W-1:0]  prev_id, prev_id_next;
  logic [TERM_LEN_W-1:0] prev_len, prev_len_next;
  logic                  lists_clear;

  // Output register
  logic                  res_valid_next;
  logic                  match_found_next;
  logic [POS_W-1:0]      match_start_next;
  logic [REC_W-1:0]      record_id_res_next;
  logic                  found_q, found_next;
  logic [POS_W-1:0]      start_q, start_next;

  // Item decode
  logic                  in_accept;
  logic                  slot_ok;
  logic [SLOT_W-1:0]     in_idx;
  logic [COUNT_W-1:0]    in_count;

  // Scan decode
  logic [SLOT_W-1:0]     cur_idx;
  logic [LEN_W-1:0]      cur_len;
  logic [TERM_ID_W-1:0]  cur_id;
  logic [TERM_LEN_W-1:0] cur_tlen;
  logic                  skip;
  logic                  past_window;
  logic                  gap_fail;
  logic [POS_W-1:0]      gap;
  logic [LEN_W-1:0]      scan_k_inc;
  logic [LEN_W-1:0]      anchor_k_inc;

  assign in_stall  = (state != ST_LOAD);
  assign in_accept = in_valid && !in_stall;
  assign in_idx    = SLOT_W'(term_slot);
  assign in_count  = COUNT_W'(term_slot) + COUNT_W'(1);
  assign slot_ok   = COUNT_W'(term_slot) < COUNT_W'(MAX_TERMS);

  assign wr_en   = in_accept && slot_ok && position_valid
                   && (list_len[in_idx] < LEN_W'(MAX_POSITIONS));
  assign wr_addr = {in_idx, list_len[in_idx][IDX_W-1:0]};

  assign cur_idx  = cur_slot[SLOT_W-1:0];
  assign cur_len  = list_len[cur_idx];
  assign cur_id   = slot_id[cur_idx];
  assign cur_tlen = slot_tlen[cur_idx];

  // Compare the fetched entry against the previous match
  assign skip        = (rd_data < prev_pos) || ((rd_data == prev_pos) && (cur_id == prev_id));
  assign past_window = {1'b0, rd_data} > ({1'b0, prev_pos} + (POS_W+1)'(window));
  assign gap         = rd_data - prev_pos;
  assign gap_fail    = gap >= (POS_W'(prev_len) + POS_W'(FINE_LIMIT));
  assign scan_k_inc  = scan_k + LEN_W'(1);
  assign anchor_k_inc = anchor_k + LEN_W'(1);

  // Write on load, read every cycle at the search address
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pos_mem[wr_addr] <= position;
    end
    rd_data <= pos_mem[rd_addr];
  end

  // Search sequencer and next values
  always_comb begin
    state_next         = state;
    term_count_next    = term_count;
    anchor_k_next      = anchor_k;
    scan_k_next        = scan_k;
    cur_slot_next      = cur_slot;
    anchor_pos_next    = anchor_pos;
    prev_pos_next      = prev_pos;
    prev_id_next       = prev_id;
    prev_len_next      = prev_len;
    found_next         = found_q;
    start_next         = start_q;
    rd_addr            = {SLOT_W'(0), IDX_W'(0)};
    lists_clear        = 1'b0;
    res_valid_next     = res_valid && res_stall;
    match_found_next   = match_found;
    match_start_next   = match_start;
    record_id_res_next = record_id_res;

    unique case (state)
      ST_LOAD: begin
        if (in_accept) begin
          if (slot_ok && (in_count > term_count)) begin
            term_count_next = in_count;
          end
          if (last_item) begin
            state_next = ST_START;
          end
        end
      end

      ST_START: begin
        anchor_k_next = '0;
        if (list_len[0] == '0) begin
          found_next = 1'b0;
          start_next = '0;
          state_next = ST_DONE;
        end else begin
          state_next = ST_ANCHOR;
        end
      end

      ST_ANCHOR: begin
        anchor_pos_next = rd_data;
        prev_pos_next   = rd_data;
        prev_id_next    = slot_id[0];
        prev_len_next   = slot_tlen[0];
        if (term_count == COUNT_W'(1)) begin
          found_next = 1'b1;
          start_next = rd_data;
          state_next = ST_DONE;
        end else begin
          cur_slot_next = COUNT_W'(1);
          state_next    = ST_SLOT;
        end
      end

      ST_SLOT: begin
        if (cur_len == '0) begin
          // empty list: drop this anchor
          anchor_k_next = anchor_k_inc;
          if (anchor_k_inc == list_len[0]) begin
            found_next = 1'b0;
            start_next = '0;
            state_next = ST_DONE;
          end else begin
            rd_addr    = {SLOT_W'(0), anchor_k_inc[IDX_W-1:0]};
            state_next = ST_ANCHOR;
          end
        end else begin
          rd_addr     = {cur_idx, IDX_W'(0)};
          scan_k_next = '0;
          state_next  = ST_SCAN;
        end
      end

      ST_SCAN: begin
        priority if (skip && (scan_k_inc != cur_len)) begin
          // advance to the next entry of this list
          rd_addr     = {cur_idx, scan_k_inc[IDX_W-1:0]};
          scan_k_next = scan_k_inc;
        end else if (skip || past_window || gap_fail) begin
          // list ran out or the gap is too wide: drop this anchor
          anchor_k_next = anchor_k_inc;
          if (anchor_k_inc == list_len[0]) begin
            found_next = 1'b0;
            start_next = '0;
            state_next = ST_DONE;
          end else begin
            rd_addr    = {SLOT_W'(0), anchor_k_inc[IDX_W-1:0]};
            state_next = ST_ANCHOR;
          end
        end else begin
          // hit: hold the match and move to the next slot
          prev_pos_next = rd_data;
          prev_id_next  = cur_id;
          prev_len_next = cur_tlen;
          if ((cur_slot + COUNT_W'(1)) == term_count) begin
            found_next = 1'b1;
            start_next = anchor_pos;
            state_next = ST_DONE;
          end else begin
            cur_slot_next = cur_slot + COUNT_W'(1);
            state_next    = ST_SLOT;
          end
        end
      end

      ST_DONE: begin
        if (!res_valid || !res_stall) begin
          res_valid_next     = 1'b1;
          match_found_next   = found_q;
          match_start_next   = start_q;
          record_id_res_next = rec_q;
          term_count_next    = '0;
          lists_clear        = 1'b1;
          state_next         = ST_LOAD;
        end
      end

      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      term_count <= '0;
      res_valid  <= 1'b0;
      window     <= WINDOW_W'(WINDOW_RESET);
      for (int i = 0; i < MAX_TERMS; i++) begin
        list_len[i] <= '0;
      end
    end else begin
      state      <= state_next;
      term_count <= term_count_next;
      res_valid  <= res_valid_next;
      if (cfg_wr_en) begin
        window <= cfg_wr_data;
      end
      if (lists_clear) begin
        for (int i = 0; i < MAX_TERMS; i++) begin
          list_len[i] <= '0;
        end
      end else if (wr_en) begin
        list_len[in_idx] <= list_len[in_idx] + LEN_W'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    anchor_k      <= anchor_k_next;
    scan_k        <= scan_k_next;
    cur_slot      <= cur_slot_next;
    anchor_pos    <= anchor_pos_next;
    prev_pos      <= prev_pos_next;
    prev_id       <= prev_id_next;
    prev_len      <= prev_len_next;
    found_q       <= found_next;
    start_q       <= start_next;
    match_found   <= match_found_next;
    match_start   <= match_start_next;
    record_id_res <= record_id_res_next;
    if (in_accept) begin
      rec_q <= record_id;
      if (slot_ok) begin
        slot_id[in_idx]   <= term_id;
        slot_tlen[in_idx] <= term_length;
      end
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    term_count <= COUNT_W'(MAX_TERMS))
    else $error("term count above slot count");

  a_last_starts_search: assert property (@(posedge clk) disable iff (rst)
    in_accept && last_item |=> (state == ST_START) && in_stall)
    else $error("last item did not start the search");

  a_scan_slot_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (cur_slot != '0) && (cur_slot < term_count)
                           && (scan_k < cur_len))
    else $error("scan outside loaded lists");

  a_done_emits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) && (!res_valid || !res_stall) |=> res_valid && (state == ST_LOAD)
      && (term_count == '0))
    else $error("finished search did not load the result");

endmodule
